/* rtl/hdt_pkg.sv */
package hdt_pkg;

  localparam int DEPTH     = 128;
  localparam int MAX_BYTES = 4096;

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);

  // Fixed field widths of the channels
  localparam int REF_W   = 32;
  localparam int LEN_W   = 16;
  localparam int IDX_W   = 32;
  localparam int CAPIN_W = 16;
  localparam int TOTAL_W = 32;
  localparam int TBYTES_W = 13;
  localparam int COUNT_W  = 8;

  localparam int ENTRY_OVERHEAD = 32;
  // name + value + overhead never overflows this
  localparam int SIZE_W = LEN_W + 2;
  localparam int RAM_W  = REF_W + 2 * LEN_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_GET    = 2'd1,
    KIND_SETCAP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DROP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;       // latch a new transaction
    logic clear;        // empty the table, count held entries as dropped
    logic count_insert; // too-large insert: count it inserted and dropped
    logic rd_oldest;    // read the oldest slot for an eviction
    logic rd_get;       // read the slot hit by a get
    logic miss;         // get outside the window
    logic drop;         // retire the oldest entry using the read data
    logic write;        // append the pending entry
    logic load_out;     // load the result register
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       too_big;
    logic       cap_zero;
    logic       evict_needed;
    logic       get_hit;
  } stat_t;

endpackage

/* rtl/hdt_ram.sv */
module hdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hdt_ctrl.sv */
module hdt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  hdt_pkg::stat_t stat,
  output hdt_pkg::cmd_t  cmd
);

  hdt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic in_open;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_open   = (state_r == hdt_pkg::ST_IDLE) ||
                     ((state_r == hdt_pkg::ST_DONE) && out_free);
  assign in_stall  = !in_open;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hdt_pkg::ST_DECIDE;
        end
      end
      hdt_pkg::ST_DECIDE: begin
        state_nxt = hdt_pkg::ST_DONE;
        if ((stat.kind == hdt_pkg::KIND_INSERT && !stat.too_big && stat.evict_needed) ||
            (stat.kind == hdt_pkg::KIND_SETCAP && !stat.cap_zero && stat.evict_needed)) begin
          state_nxt = hdt_pkg::ST_DROP;
        end
      end
      hdt_pkg::ST_DROP: begin
        state_nxt = hdt_pkg::ST_DECIDE;
      end
      hdt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = in_valid ? hdt_pkg::ST_DECIDE : hdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.accept = in_open && in_valid;
    case (state_r)
      hdt_pkg::ST_DECIDE: begin
        case (stat.kind)
          hdt_pkg::KIND_INSERT: begin
            if (stat.too_big) begin
              cmd.clear        = 1'b1;
              cmd.count_insert = 1'b1;
            end else if (stat.evict_needed) begin
              cmd.rd_oldest = 1'b1;
            end else begin
              cmd.write = 1'b1;
            end
          end
          hdt_pkg::KIND_GET: begin
            cmd.rd_get = stat.get_hit;
            cmd.miss   = !stat.get_hit;
          end
          hdt_pkg::KIND_SETCAP: begin
            if (stat.cap_zero) begin
              cmd.clear = 1'b1;
            end else begin
              cmd.rd_oldest = stat.evict_needed;
            end
          end
          default: begin
          end
        endcase
      end
      hdt_pkg::ST_DROP: begin
        cmd.drop = 1'b1;
      end
      hdt_pkg::ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hdt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result is only loaded once the previous one has gone
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // an eviction read is always followed by the drop that consumes it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_oldest |=> cmd.drop)
    else $error("eviction read not consumed");

  // no new transaction while an item is still being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hdt_pkg::ST_DECIDE || state_r == hdt_pkg::ST_DROP) |-> in_stall)
    else $error("input taken mid-item");

endmodule

/* rtl/hdt_dpath.sv */
module hdt_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hdt_pkg::cmd_t                 cmd,
  output hdt_pkg::stat_t                stat,
  input  logic [1:0]                    in_kind,
  input  logic [hdt_pkg::REF_W-1:0]     in_entry_ref,
  input  logic [hdt_pkg::LEN_W-1:0]     in_name_length,
  input  logic [hdt_pkg::LEN_W-1:0]     in_value_length,
  input  logic [hdt_pkg::IDX_W-1:0]     in_absolute_index,
  input  logic [hdt_pkg::CAPIN_W-1:0]   in_new_capacity,
  output logic                          out_status,
  output logic [hdt_pkg::REF_W-1:0]     out_found_ref,
  output logic [hdt_pkg::LEN_W-1:0]     out_found_name_length,
  output logic [hdt_pkg::LEN_W-1:0]     out_found_value_length,
  output logic [hdt_pkg::TBYTES_W-1:0]  out_table_bytes,
  output logic [hdt_pkg::COUNT_W-1:0]   out_entry_count,
  output logic [hdt_pkg::TOTAL_W-1:0]   out_inserted_total,
  output logic [hdt_pkg::COUNT_W-1:0]   out_evicted_now
);

  localparam int SLOT_W  = hdt_pkg::SLOT_W;
  localparam int CNT_W   = hdt_pkg::CNT_W;
  localparam int BYTES_W = hdt_pkg::BYTES_W;
  localparam int SIZE_W  = hdt_pkg::SIZE_W;
  localparam int REF_W   = hdt_pkg::REF_W;
  localparam int LEN_W   = hdt_pkg::LEN_W;
  localparam int TOTAL_W = hdt_pkg::TOTAL_W;
  localparam int RAM_W   = hdt_pkg::RAM_W;
  localparam int CAPIN_W = hdt_pkg::CAPIN_W;
  localparam int CAP_CMP_W = (CAPIN_W > BYTES_W) ? CAPIN_W : BYTES_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(hdt_pkg::DEPTH - 1);

  // pending transaction
  logic [1:0]           kind_r;
  logic [REF_W-1:0]     ref_r;
  logic [LEN_W-1:0]     nlen_r, vlen_r;
  logic [31:0]          aidx_r;
  logic [SIZE_W-1:0]    sz_r;

  // table state
  logic [SLOT_W-1:0]    oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]    next_r, next_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [BYTES_W-1:0]   used_r, used_nxt;
  logic [BYTES_W-1:0]   cap_r;
  logic [TOTAL_W-1:0]   ins_r, ins_nxt;
  logic [TOTAL_W-1:0]   drop_r, drop_nxt;
  logic [CNT_W-1:0]     evict_r, evict_nxt;
  logic                 hit_r;
  logic                 miss_r;

  logic [RAM_W-1:0]     rdata;
  logic [SLOT_W-1:0]    raddr;
  logic [SLOT_W-1:0]    get_slot;
  logic [CNT_W:0]       slot_sum;
  logic [31:0]          rel;
  logic [SIZE_W-1:0]    need;
  logic [SIZE_W:0]      fill;
  logic [SIZE_W-1:0]    drop_size;
  logic [CAP_CMP_W-1:0] cap_clamped;

  // size of the entry being evicted
  assign drop_size = SIZE_W'(rdata[2*LEN_W-1:LEN_W]) + SIZE_W'(rdata[LEN_W-1:0]) +
                     SIZE_W'(hdt_pkg::ENTRY_OVERHEAD);

  // absolute index to ring slot
  assign rel      = aidx_r - drop_r;
  assign slot_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(rel[CNT_W-1:0]);
  assign get_slot = (slot_sum >= (CNT_W+1)'(hdt_pkg::DEPTH)) ?
                    SLOT_W'(slot_sum - (CNT_W+1)'(hdt_pkg::DEPTH)) : SLOT_W'(slot_sum);

  assign need = (kind_r == hdt_pkg::KIND_INSERT) ? sz_r : '0;
  assign fill = (SIZE_W+1)'(used_r) + (SIZE_W+1)'(need);

  assign stat.kind     = kind_r;
  assign stat.too_big  = sz_r > SIZE_W'(cap_r);
  assign stat.cap_zero = (cap_r == '0);
  // evict while over capacity, or once more when an insert finds the ring full
  assign stat.evict_needed = (held_r != '0) &&
      ((fill > (SIZE_W+1)'(cap_r)) ||
       ((kind_r == hdt_pkg::KIND_INSERT) && (held_r >= CNT_W'(hdt_pkg::DEPTH))));
  assign stat.get_hit  = rel < 32'(held_r);

  assign cap_clamped = (CAP_CMP_W'(in_new_capacity) > CAP_CMP_W'(hdt_pkg::MAX_BYTES)) ?
                       CAP_CMP_W'(hdt_pkg::MAX_BYTES) : CAP_CMP_W'(in_new_capacity);

  assign raddr = cmd.rd_get ? get_slot : oldest_r;

  hdt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (hdt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (next_r),
    .wdata ({ref_r, nlen_r, vlen_r}),
    .re    (cmd.rd_get || cmd.rd_oldest),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    oldest_nxt = oldest_r;
    next_nxt   = next_r;
    held_nxt   = held_r;
    used_nxt   = used_r;
    ins_nxt    = ins_r;
    drop_nxt   = drop_r;
    evict_nxt  = evict_r;
    if (cmd.accept) begin
      evict_nxt = '0;
    end
    if (cmd.clear) begin
      drop_nxt   = drop_r + TOTAL_W'(held_r) + TOTAL_W'(cmd.count_insert);
      evict_nxt  = evict_r + held_r;
      oldest_nxt = '0;
      next_nxt   = '0;
      held_nxt   = '0;
      used_nxt   = '0;
    end
    if (cmd.count_insert) begin
      ins_nxt = ins_r + TOTAL_W'(1);
    end
    if (cmd.drop) begin
      used_nxt   = (drop_size > SIZE_W'(used_r)) ? '0 : used_r - BYTES_W'(drop_size);
      oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + SLOT_W'(1);
      held_nxt   = held_r - CNT_W'(1);
      drop_nxt   = drop_r + TOTAL_W'(1);
      evict_nxt  = evict_r + CNT_W'(1);
    end
    if (cmd.write) begin
      next_nxt = (next_r == LAST_SLOT) ? '0 : next_r + SLOT_W'(1);
      held_nxt = held_r + CNT_W'(1);
      used_nxt = used_r + BYTES_W'(sz_r);
      ins_nxt  = ins_r + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      next_r   <= '0;
      held_r   <= '0;
      used_r   <= '0;
      cap_r    <= '0;
      ins_r    <= '0;
      drop_r   <= '0;
      evict_r  <= '0;
      hit_r    <= 1'b0;
      miss_r   <= 1'b0;
      kind_r   <= hdt_pkg::KIND_INSERT;
    end else begin
      oldest_r <= oldest_nxt;
      next_r   <= next_nxt;
      held_r   <= held_nxt;
      used_r   <= used_nxt;
      ins_r    <= ins_nxt;
      drop_r   <= drop_nxt;
      evict_r  <= evict_nxt;
      if (cmd.accept) begin
        kind_r <= in_kind;
        hit_r  <= 1'b0;
        miss_r <= 1'b0;
        // capacity takes effect before the eviction check
        if (in_kind == hdt_pkg::KIND_SETCAP) begin
          cap_r <= BYTES_W'(cap_clamped);
        end
      end
      if (cmd.rd_get) begin
        hit_r <= 1'b1;
      end
      if (cmd.miss) begin
        miss_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ref_r  <= in_entry_ref;
      nlen_r <= in_name_length;
      vlen_r <= in_value_length;
      aidx_r <= in_absolute_index;
      sz_r   <= SIZE_W'(in_name_length) + SIZE_W'(in_value_length) +
                SIZE_W'(hdt_pkg::ENTRY_OVERHEAD);
    end
    if (cmd.load_out) begin
      out_status             <= miss_r;
      out_found_ref          <= hit_r ? rdata[RAM_W-1:2*LEN_W] : '0;
      out_found_name_length  <= hit_r ? rdata[2*LEN_W-1:LEN_W] : '0;
      out_found_value_length <= hit_r ? rdata[LEN_W-1:0] : '0;
      out_table_bytes        <= hdt_pkg::TBYTES_W'(used_r);
      out_entry_count        <= hdt_pkg::COUNT_W'(held_r);
      out_inserted_total     <= ins_r;
      out_evicted_now        <= hdt_pkg::COUNT_W'(evict_r);
    end
  end

  // every insertion is either still held or counted as dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    drop_r + TOTAL_W'(held_r) == ins_r)
    else $error("insert/drop accounting broken");

  assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(hdt_pkg::DEPTH))
    else $error("ring overfilled");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (held_r < CNT_W'(hdt_pkg::DEPTH) && fill <= (SIZE_W+1)'(cap_r)))
    else $error("append without room");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |-> held_r != '0)
    else $error("eviction from empty table");

endmodule

/* rtl/header_dynamic_table_ring.sv */
// Header-compression dynamic table in a ring of entries.
// Input channel (in_*): one transaction per item. in_kind selects insert,
// get by absolute index, or set capacity; unused fields are ignored.
// Result channel (out_*): exactly one result per item, in order, carrying
// the get result (or zeros), the byte and entry counts after the item, the
// running insert count and how many entries the item evicted or cleared.
// Each item passes the decide and done states before out_valid; each evicted
// entry adds a registered read of the oldest slot and a drop step that
// retires it. A clear (too-large insert or zero capacity) is done within
// the decide step. No new item is taken while one is being worked on; the
// next item is taken in the same cycle the previous result is loaded.
// Reset: table empty, capacity zero, counters zero; no clearing pass, the
// entry RAM is never read outside the valid window.
// Receiver stall: the result register holds; a new item may be accepted
// and worked on, but its result waits until the held one is taken.
module header_dynamic_table_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [hdt_pkg::REF_W-1:0]     in_entry_ref,
  input  logic [hdt_pkg::LEN_W-1:0]     in_name_length,
  input  logic [hdt_pkg::LEN_W-1:0]     in_value_length,
  input  logic [hdt_pkg::IDX_W-1:0]     in_absolute_index,
  input  logic [hdt_pkg::CAPIN_W-1:0]   in_new_capacity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [hdt_pkg::REF_W-1:0]     out_found_ref,
  output logic [hdt_pkg::LEN_W-1:0]     out_found_name_length,
  output logic [hdt_pkg::LEN_W-1:0]     out_found_value_length,
  output logic [hdt_pkg::TBYTES_W-1:0]  out_table_bytes,
  output logic [hdt_pkg::COUNT_W-1:0]   out_entry_count,
  output logic [hdt_pkg::TOTAL_W-1:0]   out_inserted_total,
  output logic [hdt_pkg::COUNT_W-1:0]   out_evicted_now
);

  hdt_pkg::cmd_t  cmd;
  hdt_pkg::stat_t stat;

  hdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hdt_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_kind                (in_kind),
    .in_entry_ref           (in_entry_ref),
    .in_name_length         (in_name_length),
    .in_value_length        (in_value_length),
    .in_absolute_index      (in_absolute_index),
    .in_new_capacity        (in_new_capacity),
    .out_status             (out_status),
    .out_found_ref          (out_found_ref),
    .out_found_name_length  (out_found_name_length),
    .out_found_value_length (out_found_value_length),
    .out_table_bytes        (out_table_bytes),
    .out_entry_count        (out_entry_count),
    .out_inserted_total     (out_inserted_total),
    .out_evicted_now        (out_evicted_now)
  );

endmodule

/* sim/tb_header_dynamic_table_ring.sv */
module tb_header_dynamic_table_ring;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                         status;
    logic [hdt_pkg::REF_W-1:0]    handle;
    logic [hdt_pkg::LEN_W-1:0]    nm_bytes;
    logic [hdt_pkg::LEN_W-1:0]    val_bytes;
    logic [hdt_pkg::TBYTES_W-1:0] bytes;
    logic [hdt_pkg::COUNT_W-1:0]  count;
    logic [hdt_pkg::TOTAL_W-1:0]  inserted;
    logic [hdt_pkg::COUNT_W-1:0]  evicted;
  } table_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_kind = '0;
  logic [hdt_pkg::REF_W-1:0]     in_entry_ref = '0;
  logic [hdt_pkg::LEN_W-1:0]     in_name_length = '0;
  logic [hdt_pkg::LEN_W-1:0]     in_value_length = '0;
  logic [hdt_pkg::IDX_W-1:0]     in_absolute_index = '0;
  logic [hdt_pkg::CAPIN_W-1:0]   in_new_capacity = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_status;
  logic [hdt_pkg::REF_W-1:0]     out_found_ref;
  logic [hdt_pkg::LEN_W-1:0]     out_found_name_length;
  logic [hdt_pkg::LEN_W-1:0]     out_found_value_length;
  logic [hdt_pkg::TBYTES_W-1:0]  out_table_bytes;
  logic [hdt_pkg::COUNT_W-1:0]   out_entry_count;
  logic [hdt_pkg::TOTAL_W-1:0]   out_inserted_total;
  logic [hdt_pkg::COUNT_W-1:0]   out_evicted_now;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;

  table_result_t table_results[$];
  table_result_t want;

  // Mirror of the table contents and counters
  logic [hdt_pkg::REF_W-1:0] mirror_handle    [hdt_pkg::DEPTH];
  logic [hdt_pkg::LEN_W-1:0] mirror_nm_bytes  [hdt_pkg::DEPTH];
  logic [hdt_pkg::LEN_W-1:0] mirror_val_bytes [hdt_pkg::DEPTH];
  int unsigned      mirror_oldest = 0;
  int unsigned      mirror_next = 0;
  int unsigned      mirror_held = 0;
  int unsigned      mirror_used = 0;
  int unsigned      mirror_capacity = 0;
  logic [31:0]      mirror_inserted = '0;
  logic [31:0]      mirror_dropped = '0;

  header_dynamic_table_ring DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_entry_ref           (in_entry_ref),
    .in_name_length         (in_name_length),
    .in_value_length        (in_value_length),
    .in_absolute_index      (in_absolute_index),
    .in_new_capacity        (in_new_capacity),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_found_ref          (out_found_ref),
    .out_found_name_length  (out_found_name_length),
    .out_found_value_length (out_found_value_length),
    .out_table_bytes        (out_table_bytes),
    .out_entry_count        (out_entry_count),
    .out_inserted_total     (out_inserted_total),
    .out_evicted_now        (out_evicted_now)
  );

  always #4 clk = ~clk;

  function automatic int unsigned footprint(logic [hdt_pkg::LEN_W-1:0] n,
      logic [hdt_pkg::LEN_W-1:0] v);
    return int'(n) + int'(v) + hdt_pkg::ENTRY_OVERHEAD;
  endfunction

  function automatic void mirror_drop_oldest();
    int unsigned sz;
    sz = footprint(mirror_nm_bytes[mirror_oldest], mirror_val_bytes[mirror_oldest]);
    mirror_used = (sz > mirror_used) ? 0 : mirror_used - sz;
    mirror_oldest = (mirror_oldest + 1) % hdt_pkg::DEPTH;
    mirror_held--;
    mirror_dropped++;
  endfunction

  function automatic int unsigned mirror_clear();
    int unsigned n;
    n = mirror_held;
    mirror_dropped += n;
    mirror_oldest = 0;
    mirror_next = 0;
    mirror_held = 0;
    mirror_used = 0;
    return n;
  endfunction

  function automatic table_result_t predict_table_result(hdt_pkg::kind_t kind,
      logic [hdt_pkg::REF_W-1:0] handle, logic [hdt_pkg::LEN_W-1:0] nlen,
      logic [hdt_pkg::LEN_W-1:0] vlen, logic [hdt_pkg::IDX_W-1:0] idx,
      logic [hdt_pkg::CAPIN_W-1:0] cap);
    table_result_t r;
    int unsigned   sz;
    int unsigned   lim;
    int unsigned   evicted;
    int unsigned   s;
    logic [31:0]   rel;
    r = '{default: '0};
    evicted = 0;
    case (kind)
      hdt_pkg::KIND_INSERT: begin
        sz = footprint(nlen, vlen);
        if (sz > mirror_capacity) begin
          // too large: table cleared, entry counted as inserted and dropped
          evicted = mirror_clear();
          mirror_inserted++;
          mirror_dropped++;
        end else begin
          while (mirror_held > 0 && mirror_used + sz > mirror_capacity) begin
            mirror_drop_oldest();
            evicted++;
          end
          if (mirror_held >= hdt_pkg::DEPTH) begin
            mirror_drop_oldest();
            evicted++;
          end
          mirror_handle[mirror_next]    = handle;
          mirror_nm_bytes[mirror_next]  = nlen;
          mirror_val_bytes[mirror_next] = vlen;
          mirror_next = (mirror_next + 1) % hdt_pkg::DEPTH;
          mirror_held++;
          mirror_used += sz;
          mirror_inserted++;
        end
      end
      hdt_pkg::KIND_GET: begin
        // window test is modular so it survives counter wrap
        rel = idx - mirror_dropped;
        if (rel < mirror_held) begin
          s = (mirror_oldest + rel) % hdt_pkg::DEPTH;
          r.handle    = mirror_handle[s];
          r.nm_bytes  = mirror_nm_bytes[s];
          r.val_bytes = mirror_val_bytes[s];
        end else begin
          r.status = 1'b1;
        end
      end
      hdt_pkg::KIND_SETCAP: begin
        lim = (cap > hdt_pkg::MAX_BYTES) ? hdt_pkg::MAX_BYTES : cap;
        mirror_capacity = lim;
        if (lim == 0) begin
          evicted = mirror_clear();
        end else begin
          while (mirror_held > 0 && mirror_used > mirror_capacity) begin
            mirror_drop_oldest();
            evicted++;
          end
        end
      end
      default: ;
    endcase
    r.bytes    = mirror_used[hdt_pkg::TBYTES_W-1:0];
    r.count    = mirror_held[hdt_pkg::COUNT_W-1:0];
    r.inserted = mirror_inserted;
    r.evicted  = evicted[hdt_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(hdt_pkg::kind_t kind, logic [hdt_pkg::REF_W-1:0] handle,
      logic [hdt_pkg::LEN_W-1:0] nlen, logic [hdt_pkg::LEN_W-1:0] vlen,
      logic [hdt_pkg::IDX_W-1:0] idx, logic [hdt_pkg::CAPIN_W-1:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_kind           <= kind;
    in_entry_ref      <= handle;
    in_name_length    <= nlen;
    in_value_length   <= vlen;
    in_absolute_index <= idx;
    in_new_capacity   <= cap;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    table_results.push_back(predict_table_result(kind, handle, nlen, vlen, idx, cap));
    @(negedge clk);
  endtask

  task automatic do_insert(logic [hdt_pkg::REF_W-1:0] handle, logic [hdt_pkg::LEN_W-1:0] nlen,
      logic [hdt_pkg::LEN_W-1:0] vlen);
    send_item(hdt_pkg::KIND_INSERT, handle, nlen, vlen, $urandom(),
              hdt_pkg::CAPIN_W'($urandom()));
  endtask

  task automatic do_get(logic [hdt_pkg::IDX_W-1:0] idx);
    send_item(hdt_pkg::KIND_GET, $urandom(), hdt_pkg::LEN_W'($urandom()),
              hdt_pkg::LEN_W'($urandom()), idx, hdt_pkg::CAPIN_W'($urandom()));
  endtask

  task automatic do_setcap(logic [hdt_pkg::CAPIN_W-1:0] cap);
    send_item(hdt_pkg::KIND_SETCAP, $urandom(), hdt_pkg::LEN_W'($urandom()),
              hdt_pkg::LEN_W'($urandom()), $urandom(), cap);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (table_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [hdt_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return hdt_pkg::LEN_W'($urandom_range(150, 0));
    if (r < 95) return hdt_pkg::LEN_W'($urandom_range(2100, 151));
    return hdt_pkg::LEN_W'($urandom_range(65535, 0));
  endfunction

  function automatic logic [hdt_pkg::IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 70 && mirror_held > 0) return mirror_dropped + $urandom_range(mirror_held - 1, 0);
    if (r < 80) return mirror_dropped - 1;
    if (r < 90) return mirror_inserted + $urandom_range(2, 0);
    return $urandom();
  endfunction

  function automatic logic [hdt_pkg::CAPIN_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 20) return hdt_pkg::CAPIN_W'($urandom_range(65535, 4097));
    if (r < 40) return hdt_pkg::CAPIN_W'($urandom_range(800, 1));
    return hdt_pkg::CAPIN_W'($urandom_range(4096, 1500));
  endfunction

  task automatic test_empty_table_and_clamp();
    do_get('0);
    do_get(32'hFFFF_FFFF);
    do_insert(32'h1234_5678, '0, '0);  // capacity still zero: too large
    do_setcap(16'hFFFF);
    do_insert(32'hFFFF_FFFF, '0, '0);
    do_get(32'd1);
    do_get('0);
    drain_results();
  endtask

  task automatic test_insert_get_extremes();
    do_insert('0, 16'hFFFF, 16'hFFFF);
    do_insert(32'hA5A5_5A5A, 16'd4064, '0);  // fills capacity exactly
    do_insert(32'h5A5A_A5A5, '0, 16'd4064);
    do_get(mirror_inserted - 1);
    do_get(mirror_inserted);
    do_get(mirror_dropped - 1);
    repeat (4) do_insert($urandom(), 16'd100, 16'd200);
    drain_results();
  endtask

  task automatic test_capacity_changes();
    do_setcap(16'd500);
    do_setcap(16'd4097);
    do_setcap('0);
    do_get(mirror_dropped);
    do_setcap(16'd32);
    do_insert($urandom(), '0, '0);
    do_insert($urandom(), 16'd1, '0);
    do_setcap(16'd4096);
    drain_results();
  endtask

  // Receiver holds off while minimum-size inserts keep coming; ring wraps
  task automatic test_full_ring_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    do_setcap(16'd4096);
    drain_results();
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    repeat (140) do_insert($urandom(), '0, '0);
    do_get(mirror_dropped);
    do_get(mirror_inserted - 1);
    drain_results();
  endtask

  task automatic test_random_traffic(int items, int send_pct, int recv_pct);
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 45) do_insert($urandom(), pick_length(), pick_length());
      else if (pick < 85) do_get(pick_index());
      else do_setcap(pick_capacity());
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(string fname, logic [31:0] expv, logic [31:0] got);
    if (got !== expv) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, fname, expv, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (table_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no transaction outstanding", $realtime);
      end else begin
        want = table_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("found_ref", want.handle, out_found_ref);
        check_field("found_name_length", want.nm_bytes, out_found_name_length);
        check_field("found_value_length", want.val_bytes, out_found_value_length);
        check_field("table_bytes", want.bytes, out_table_bytes);
        check_field("entry_count", want.count, out_entry_count);
        check_field("inserted_total", want.inserted, out_inserted_total);
        check_field("evicted_now", want.evicted, out_evicted_now);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_table_and_clamp();
    test_insert_get_extremes();
    test_capacity_changes();
    test_full_ring_backpressure();
    test_random_traffic(330, 29, 60);
    test_random_traffic(330, 60, 29);
    test_random_traffic(322, 0, 0);
    repeat (20) @(posedge clk);
    if (table_results.size() != 0) begin
      mismatches++;
      $display("%0d transactions never produced a result", table_results.size());
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
